// ===== rtl/core/gpc_pkg.sv =====
// Shared types and constants for the Gear predictor-corrector step block.
// Holds the operation codes, register indexes, reset values, state types
// and the 48-bit saturation helper. No dependencies.
package gpc_pkg;

  localparam int W = 48;

  typedef logic signed [W-1:0] word_t;

  // operation carried in tuser
  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_PRED = 2'd1,
    OP_CORR = 2'd2,
    OP_READ = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [1:0] CFG_STEP = 2'd0;
  localparam logic [1:0] CFG_INV  = 2'd1;
  localparam logic [1:0] CFG_HSS  = 2'd2;

  // register reset values, unsigned Q16.32
  localparam logic [W-1:0] STEP_RST = 48'd16777216;
  localparam logic [W-1:0] INV_RST  = 48'd1099511627776;
  localparam logic [W-1:0] HSS_RST  = 48'd32768;

  localparam word_t WMAX = {1'b0, {(W-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(W-1){1'b0}}};

  // command from the controller to every lane
  typedef struct packed {
    logic start;
    logic clr_we;
    op_t  op;
  } gpc_cmd_t;

  typedef enum logic [3:0] {
    L_IDLE,
    L_READ,
    L_LOAD,
    L_PRED,
    L_INIT_W,
    L_FMUL_W,
    L_DIV_W,
    L_CMUL,
    L_CMUL_W,
    L_WRITE,
    L_VMUL_W,
    L_DONE
  } lane_state_t;

  typedef enum logic [2:0] {
    T_CLEAR,
    T_IDLE,
    T_MOD,
    T_START,
    T_RUN
  } top_state_t;

  // saturate a 53-bit signed value to 48 bits
  function automatic word_t sat53(input logic signed [52:0] v);
    word_t r;
    if (v[52:47] == {6{v[52]}}) begin
      r = v[47:0];
    end else if (v[52]) begin
      r = WMIN;
    end else begin
      r = WMAX;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/gpc_fxmul.sv =====
// Sequential fixed-point multiplier: 49-bit magnitude by 48-bit unsigned,
// one 16-bit slice per cycle, then round half away from zero and saturate.
// Depends on gpc_pkg.
module gpc_fxmul #(
  parameter int FRACTION_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [48:0]   a_mag,
  input  logic          neg,
  input  logic [47:0]   b,
  output logic          busy,
  output logic          done,
  output gpc_pkg::word_t res,
  output logic [96:0]   prod
);
  import gpc_pkg::*;

  logic [1:0]  cnt_r;
  logic        busy_r;
  logic        fin_r;
  logic        done_r;
  logic        neg_r;
  logic [48:0] a_r;
  logic [47:0] b_r;
  logic [96:0] acc_r;
  word_t       res_r;

  logic [64:0] pp;
  logic [96:0] rnd_sum;
  logic [96:0] rnd_q;
  word_t       res_nxt;

  // one partial product per cycle, top slice first
  assign pp      = 65'(a_r) * 65'(b_r[47:32]);
  assign rnd_sum = acc_r + (97'(1) << (FRACTION_BITS - 1));
  assign rnd_q   = rnd_sum >> FRACTION_BITS;

  // apply sign and saturate
  always_comb begin
    if (!neg_r) begin
      res_nxt = (rnd_q > 97'(48'h7FFF_FFFF_FFFF)) ? WMAX : word_t'(rnd_q[47:0]);
    end else begin
      res_nxt = (rnd_q > 97'(48'h8000_0000_0000)) ? WMIN :
                word_t'(48'(0) - rnd_q[47:0]);
    end
  end

  // sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fin_r  <= 1'b0;
      done_r <= fin_r;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd2) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a_mag;
      b_r   <= b;
      neg_r <= neg;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= {acc_r[80:0], 16'b0} + 97'(pp);
      b_r   <= {b_r[31:0], 16'b0};
    end
    if (fin_r) begin
      res_r <= res_nxt;
    end
  end

  assign busy = busy_r | fin_r;
  assign done = done_r;
  assign res  = res_r;
  assign prod = acc_r;

endmodule

// ===== rtl/core/gpc_div.sv =====
// Restoring divider: 96-bit magnitude by 48-bit mass, one quotient bit per
// cycle, rounded half away from zero and saturated to 48 bits signed.
// Depends on gpc_pkg.
module gpc_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [95:0]    dvd,
  input  logic [47:0]    m,
  input  logic           neg,
  output logic           busy,
  output logic           done,
  output gpc_pkg::word_t q
);
  import gpc_pkg::*;

  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        fin_r;
  logic        done_r;
  logic [95:0] dvd_r;
  logic [48:0] rem_r;
  logic [62:0] q_r;
  logic        ovf_r;
  logic [47:0] m_r;
  logic        neg_r;
  logic        zero_r;
  word_t       q_out_r;

  logic [48:0] rem_t;
  logic        ge;
  logic        rnd_up;
  logic [63:0] qf;
  word_t       q_nxt;

  assign rem_t  = {rem_r[47:0], dvd_r[95]};
  assign ge     = rem_t >= {1'b0, m_r};
  assign rnd_up = {rem_r, 1'b0} >= {2'b0, m_r};
  assign qf     = {1'b0, q_r} + 64'(rnd_up);

  // sign, saturation and the zero-product case
  always_comb begin
    if (zero_r) begin
      q_nxt = '0;
    end else if (!neg_r) begin
      q_nxt = (ovf_r || qf > 64'h7FFF_FFFF_FFFF) ? WMAX : word_t'(qf[47:0]);
    end else begin
      q_nxt = (ovf_r || qf > 64'h8000_0000_0000) ? WMIN :
              word_t'(48'(0) - qf[47:0]);
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fin_r  <= 1'b0;
      done_r <= fin_r;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd95;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd0) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  // shift, compare and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= dvd;
      m_r    <= m;
      neg_r  <= neg;
      zero_r <= (dvd == '0);
      rem_r  <= '0;
      q_r    <= '0;
      ovf_r  <= 1'b0;
    end else if (busy_r) begin
      rem_r <= ge ? (rem_t - {1'b0, m_r}) : rem_t;
      dvd_r <= {dvd_r[94:0], 1'b0};
      q_r   <= {q_r[61:0], ge};
      if (ge && cnt_r >= 7'd63) begin
        ovf_r <= 1'b1;
      end
    end
    if (fin_r) begin
      q_out_r <= q_nxt;
    end
  end

  assign busy = busy_r | fin_r;
  assign done = done_r;
  assign q    = q_out_r;

endmodule

// ===== rtl/core/gpc_lane.sv =====
// One component lane (x, y or z): history memory for all particles, a
// sequencer, a shared multiplier and a divider. Depends on gpc_pkg,
// gpc_fxmul and gpc_div.
module gpc_lane #(
  parameter int PARTICLES     = 1024,
  parameter int FRACTION_BITS = 32,
  parameter int AW            = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gpc_pkg::gpc_cmd_t cmd,
  input  logic [AW-1:0]     addr,
  input  gpc_pkg::word_t    vec_a,
  input  gpc_pkg::word_t    vec_b,
  input  logic [47:0]       mass,
  input  logic [47:0]       step_size,
  input  logic [47:0]       inverse_step,
  input  logic [47:0]       half_step_squared,
  output logic              done,
  output gpc_pkg::word_t    pos,
  output gpc_pkg::word_t    vel
);
  import gpc_pkg::*;

  typedef enum logic [1:0] {SEL_VIN, SEL_FORCE, SEL_ERR, SEL_VOUT} mul_sel_t;

  localparam logic [63:0] COEF_Y0 = ((64'd3 << FRACTION_BITS) + 64'd8) / 64'd16;
  localparam logic [63:0] COEF_Y1 = ((64'd251 << FRACTION_BITS) + 64'd180) / 64'd360;
  localparam logic [63:0] COEF_Y3 = ((64'd11 << FRACTION_BITS) + 64'd9) / 64'd18;
  localparam logic [63:0] COEF_Y4 = ((64'd1 << FRACTION_BITS) + 64'd3) / 64'd6;
  localparam logic [63:0] COEF_Y5 = ((64'd1 << FRACTION_BITS) + 64'd30) / 64'd60;

  lane_state_t state_r, state_nxt;
  op_t         op_r;
  word_t       a_r;
  word_t       b_r;
  logic [47:0] mass_r;
  word_t       y_r [6];
  logic signed [48:0] err_r;
  logic [2:0]  k_r;
  word_t       vel_r;

  logic [287:0] mem [PARTICLES];
  logic [287:0] rd_r;
  logic [287:0] wr_data;

  // sequencer strobes
  logic     rd_en, wr_en, ld_cmd, ld_y, y_init, y_pred, err_ld, y_coef, vel_ld;
  logic     mul_start, div_start;
  mul_sel_t mul_sel;

  // multiplier and divider
  logic [48:0] mul_a;
  logic        mul_neg;
  logic [47:0] mul_b;
  logic        mul_busy, mul_done;
  word_t       mul_res;
  logic [96:0] mul_prod;
  logic        div_busy, div_done;
  word_t       div_q;

  logic signed [52:0] e [6];
  word_t              pred [5];
  logic signed [48:0] err_c;
  logic [47:0]        coef;
  logic [2:0]         tgt;

  gpc_fxmul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a_mag (mul_a),
    .neg   (mul_neg),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .res   (mul_res),
    .prod  (mul_prod)
  );

  gpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (mul_prod[95:0]),
    .m     (mass_r),
    .neg   (a_r[47]),
    .busy  (div_busy),
    .done  (div_done),
    .q     (div_q)
  );

  // history memory: one row of six words per particle
  assign wr_data = {y_r[5], y_r[4], y_r[3], y_r[2], y_r[1], y_r[0]};

  always_ff @(posedge clk) begin
    if (cmd.clr_we) begin
      mem[addr] <= '0;
    end else if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[addr];
    end
  end

  // correction coefficient and its target word
  always_comb begin
    unique case (k_r)
      3'd0:    begin coef = COEF_Y0[47:0]; tgt = 3'd0; end
      3'd1:    begin coef = COEF_Y1[47:0]; tgt = 3'd1; end
      3'd2:    begin coef = COEF_Y3[47:0]; tgt = 3'd3; end
      3'd3:    begin coef = COEF_Y4[47:0]; tgt = 3'd4; end
      default: begin coef = COEF_Y5[47:0]; tgt = 3'd5; end
    endcase
  end

  // multiplier operand select
  always_comb begin
    unique case (mul_sel)
      SEL_VIN: begin
        mul_neg = b_r[47];
        mul_a   = b_r[47] ? (49'(0) - 49'(b_r)) : 49'(b_r);
        mul_b   = step_size;
      end
      SEL_FORCE: begin
        mul_neg = a_r[47];
        mul_a   = a_r[47] ? (49'(0) - 49'(a_r)) : 49'(a_r);
        mul_b   = half_step_squared;
      end
      SEL_ERR: begin
        mul_neg = err_r[48];
        mul_a   = err_r[48] ? (49'(0) - err_r) : err_r;
        mul_b   = coef;
      end
      default: begin
        mul_neg = y_r[1][47];
        mul_a   = y_r[1][47] ? (49'(0) - 49'(y_r[1])) : 49'(y_r[1]);
        mul_b   = inverse_step;
      end
    endcase
  end

  // Pascal-triangle predictor, exact then saturated
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      e[i] = 53'(y_r[i]);
    end
    pred[0] = sat53(e[0] + e[1] + e[2] + e[3] + e[4] + e[5]);
    pred[1] = sat53(e[1] + (e[2] <<< 1) + 53'sd3 * e[3] + (e[4] <<< 2) + 53'sd5 * e[5]);
    pred[2] = sat53(e[2] + 53'sd3 * e[3] + 53'sd6 * e[4] + 53'sd10 * e[5]);
    pred[3] = sat53(e[3] + (e[4] <<< 2) + 53'sd10 * e[5]);
    pred[4] = sat53(e[4] + 53'sd5 * e[5]);
  end

  assign err_c = 49'(y_r[2]) - 49'(div_q);

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and strobes
  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    ld_cmd    = 1'b0;
    ld_y      = 1'b0;
    y_init    = 1'b0;
    y_pred    = 1'b0;
    err_ld    = 1'b0;
    y_coef    = 1'b0;
    vel_ld    = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_sel   = SEL_VOUT;
    unique case (state_r)
      L_IDLE, L_DONE: begin
        if (cmd.start) begin
          ld_cmd    = 1'b1;
          state_nxt = L_READ;
        end
      end
      L_READ: begin
        rd_en     = 1'b1;
        state_nxt = L_LOAD;
      end
      L_LOAD: begin
        ld_y = 1'b1;
        unique case (op_r)
          OP_INIT: begin
            mul_sel   = SEL_VIN;
            mul_start = 1'b1;
            state_nxt = L_INIT_W;
          end
          OP_PRED: state_nxt = L_PRED;
          OP_CORR: begin
            mul_sel   = SEL_FORCE;
            mul_start = 1'b1;
            state_nxt = L_FMUL_W;
          end
          default: state_nxt = L_WRITE;
        endcase
      end
      L_PRED: begin
        y_pred    = 1'b1;
        state_nxt = L_WRITE;
      end
      L_INIT_W: begin
        if (mul_done) begin
          y_init    = 1'b1;
          state_nxt = L_WRITE;
        end
      end
      L_FMUL_W: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_nxt = L_DIV_W;
        end
      end
      L_DIV_W: begin
        if (div_done) begin
          err_ld    = 1'b1;
          state_nxt = L_CMUL;
        end
      end
      L_CMUL: begin
        mul_sel   = SEL_ERR;
        mul_start = 1'b1;
        state_nxt = L_CMUL_W;
      end
      L_CMUL_W: begin
        mul_sel = SEL_ERR;
        if (mul_done) begin
          y_coef    = 1'b1;
          state_nxt = (k_r == 3'd4) ? L_WRITE : L_CMUL;
        end
      end
      L_WRITE: begin
        wr_en     = 1'b1;
        mul_sel   = SEL_VOUT;
        mul_start = 1'b1;
        state_nxt = L_VMUL_W;
      end
      L_VMUL_W: begin
        if (mul_done) begin
          vel_ld    = 1'b1;
          state_nxt = L_DONE;
        end
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (ld_cmd) begin
      op_r   <= cmd.op;
      a_r    <= vec_a;
      b_r    <= vec_b;
      mass_r <= mass;
    end
    if (ld_y) begin
      for (int i = 0; i < 6; i++) begin
        y_r[i] <= rd_r[48*i +: 48];
      end
    end
    if (y_pred) begin
      for (int i = 0; i < 5; i++) begin
        y_r[i] <= pred[i];
      end
    end
    if (y_init) begin
      y_r[0] <= a_r;
      y_r[1] <= mul_res;
    end
    if (err_ld) begin
      err_r  <= err_c;
      y_r[2] <= sat53(53'(y_r[2]) - 53'(err_c));
      k_r    <= '0;
    end
    if (y_coef) begin
      y_r[tgt] <= sat53(53'(y_r[tgt]) - 53'(mul_res));
      k_r      <= k_r + 3'd1;
    end
    if (vel_ld) begin
      vel_r <= mul_res;
    end
  end

  assign done = (state_r == L_DONE);
  assign pos  = y_r[0];
  assign vel  = vel_r;

  // a new product or quotient never starts over one in flight
  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

endmodule

// ===== rtl/core/gear_predictor_corrector_step.sv =====
// Gear fifth-order predictor-corrector step, top level.
// Instantiates three gpc_lane copies (x, y, z) and merges their results.
// Depends on gpc_pkg and gpc_lane.
//
// Usage: each input beat (in_*) names a particle and an operation in tuser:
// init, predict, correct or read only. One output beat (out_*) per input
// beat carries the particle index, position y0 and velocity y1/dt, all
// signed Q16.32. Registers dt, 1/dt and dt^2/2 are written on the cfg_*
// channel, which is always ready; write them only while no item is in work.
// After reset the history memories are cleared, one particle row per
// cycle; in_tready stays low until that ends. The block works on one
// item at a time. Correct takes longest of the operations: its time is
// set by the 96-step restoring divider and the five coefficient passes
// through each lane's 49x16 slice multiplier. With fewer than 1024
// particles the index is reduced first. A finished result waits in the
// output register while the next beat is accepted; the following result
// is held back in the lanes until out_tready takes the waiting one.
module gear_predictor_corrector_step #(
  parameter int PARTICLES     = 1024,
  parameter int FRACTION_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata, low bit up: particle_index, vec_a_x, vec_a_y, vec_a_z,
  // vec_b_x, vec_b_y, vec_b_z, mass, zero fill
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [351:0] in_tdata,
  // in_tuser: op
  input  logic [1:0]   in_tuser,
  // out_tdata, low bit up: out_index, pos_x, pos_y, pos_z, vel_x, vel_y,
  // vel_z, zero fill
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [303:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [47:0]  cfg_data
);
  import gpc_pkg::*;

  localparam int AW       = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam bit NEED_MOD = (PARTICLES < 1024);

  top_state_t  state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [3:0]  mod_k_r;
  logic [9:0]  pidx_r;
  logic [9:0]  idx_r;
  op_t         op_r;
  word_t       va_r [3];
  word_t       vb_r [3];
  logic [47:0] mass_r;
  logic [47:0] step_r, inv_r, hss_r;
  logic        out_valid_r;
  logic [303:0] out_data_r;

  gpc_cmd_t    cmd;
  logic [AW-1:0] lane_addr;
  logic [2:0]  lane_done;
  word_t       pos_l [3];
  word_t       vel_l [3];
  logic        in_acc, out_load, clr_last;
  logic [31:0] mod_sub;

  assign in_acc    = in_tvalid && in_tready;
  assign clr_last  = (clr_cnt_r == AW'(PARTICLES - 1));
  assign out_load  = (state_r == T_RUN) && (&lane_done) && (!out_valid_r || out_tready);
  assign mod_sub   = 32'(PARTICLES) << mod_k_r;
  assign lane_addr = (state_r == T_CLEAR) ? clr_cnt_r : AW'(idx_r);

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RST;
      inv_r  <= INV_RST;
      hss_r  <= HSS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STEP: step_r <= cfg_data;
        CFG_INV:  inv_r  <= cfg_data;
        CFG_HSS:  hss_r  <= cfg_data;
        default:  ;
      endcase
    end
  end

  // controller state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and lane command
  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd.start  = 1'b0;
    cmd.clr_we = 1'b0;
    cmd.op     = op_r;
    unique case (state_r)
      T_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (clr_last) begin
          state_nxt = T_IDLE;
        end
      end
      T_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = NEED_MOD ? T_MOD : T_START;
        end
      end
      T_MOD: begin
        if (mod_k_r == 4'd0) begin
          state_nxt = T_START;
        end
      end
      T_START: begin
        cmd.start = 1'b1;
        state_nxt = T_RUN;
      end
      T_RUN: begin
        if (out_load) begin
          state_nxt = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  // clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (state_r == T_CLEAR && !clr_last) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // capture the beat; reduce the index one binary step per cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pidx_r  <= in_tdata[9:0];
      idx_r   <= in_tdata[9:0];
      mod_k_r <= 4'd9;
      op_r    <= op_t'(in_tuser);
      va_r[0] <= in_tdata[57:10];
      va_r[1] <= in_tdata[105:58];
      va_r[2] <= in_tdata[153:106];
      vb_r[0] <= in_tdata[201:154];
      vb_r[1] <= in_tdata[249:202];
      vb_r[2] <= in_tdata[297:250];
      mass_r  <= in_tdata[345:298];
    end else if (state_r == T_MOD) begin
      if (32'(idx_r) >= mod_sub) begin
        idx_r <= idx_r - mod_sub[9:0];
      end
      mod_k_r <= mod_k_r - 4'd1;
    end
  end

  // component lanes
  for (genvar g = 0; g < 3; g++) begin : g_lane
    gpc_lane #(
      .PARTICLES     (PARTICLES),
      .FRACTION_BITS (FRACTION_BITS),
      .AW            (AW)
    ) u_lane (
      .clk               (clk),
      .rst_n             (rst_n),
      .cmd               (cmd),
      .addr              (lane_addr),
      .vec_a             (va_r[g]),
      .vec_b             (vb_r[g]),
      .mass              (mass_r),
      .step_size         (step_r),
      .inverse_step      (inv_r),
      .half_step_squared (hss_r),
      .done              (lane_done[g]),
      .pos               (pos_l[g]),
      .vel               (vel_l[g])
    );
  end

  // merge lane results into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {6'b0, vel_l[2], vel_l[1], vel_l[0],
                     pos_l[2], pos_l[1], pos_l[0], pidx_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // lanes run the same sequence and finish together
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    lane_done == 3'b000 || lane_done == 3'b111)
    else $error("lanes out of step");

  // a result beat appears only when the lanes complete an item
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == T_RUN && (&lane_done)))
    else $error("output beat without finished item");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second beat accepted during work");

endmodule
